/* rtl/nearby_sighting_table_unit_macros.svh */
// Assertion macros used by the sighting table top level
`ifndef NEARBY_SIGHTING_TABLE_UNIT_MACROS_SVH
`define NEARBY_SIGHTING_TABLE_UNIT_MACROS_SVH

// implication check, reset-qualified
`define NST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication check, reset-qualified
`define NST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/nst_pkg.sv */
// Package: widths, codes and entry type for the sighting table
`timescale 1ns / 1ps
package nst_pkg;
	localparam int unsigned TableDepth = 8;
	localparam int unsigned IdxW = $clog2(TableDepth);
	localparam int unsigned CntW = $clog2(TableDepth + 1);
	localparam logic [31:0] ResetExpiry = 32'd15000;

	localparam logic [1:0] KIND_SIGHT = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_QUERY = 2'd3;

	// register byte addresses
	localparam logic [1:0] ADDR_EXPIRY = 2'd0;

	typedef struct packed {
		logic [63:0] key;
		logic        shares;
		logic [7:0]  game;
		logic [31:0] score;
		logic signed [7:0] signal;
		logic [31:0] seen;
	} entry_t;

	// memory port request from controller
	typedef struct packed {
		logic            we;
		logic [IdxW-1:0] waddr;
		entry_t          wdata;
		logic [IdxW-1:0] raddr;
	} mem_req_t;
endpackage

/* rtl/nst_mem.sv */
// Entry memory: one write port, one registered read port
`timescale 1ns / 1ps
module nst_mem (
	input  logic              clk,
	input  nst_pkg::mem_req_t req,
	output nst_pkg::entry_t   rdata
);
	nst_pkg::entry_t mem_q [nst_pkg::TableDepth];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata <= mem_q[req.raddr];
	end
endmodule

/* rtl/nst_ctrl.sv */
// Sequencer: scans the entry memory for each tick, sighting and query, and builds the result
`timescale 1ns / 1ps
module nst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  nst_pkg::entry_t   in_entry,
	input  logic [2:0]        rank,
	input  logic [31:0]       expiry,
	output nst_pkg::mem_req_t req,
	input  nst_pkg::entry_t   rdata,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [182:0]      out_data,
	output logic [nst_pkg::CntW-1:0] count_o
);
	localparam int unsigned IW = nst_pkg::IdxW;
	localparam int unsigned CW = nst_pkg::CntW;
	localparam logic [CW-1:0] Depth = CW'(nst_pkg::TableDepth);

	typedef enum logic [2:0] {IDLE, SCAN, OUTER, INNER, WRITE, DONE} state_t;
	state_t state_q;

	logic [1:0]        kind_q;
	nst_pkg::entry_t   item_q;
	logic [2:0]        rank_q;
	logic [CW-1:0]     used_q, kept_q, i_q, j_q, pos_q;
	logic [31:0]       chg_q;
	logic              found_q, rvalid_q, keep_q, hit_q;
	logic [IW-1:0]     weak_q, slot_q;
	logic signed [7:0] weak_sig_q;
	nst_pkg::entry_t   cand_q, res_q;

	logic [31:0] age;
	assign age = item_q.seen - rdata.seen;

	always_comb begin
		req.we    = 1'b0;
		req.waddr = slot_q;
		req.wdata = item_q;
		req.raddr = i_q[IW-1:0];
		unique case (state_q)
			INNER: req.raddr = j_q[IW-1:0];
			OUTER: req.raddr = i_q[IW-1:0];
			SCAN: if (kind_q == nst_pkg::KIND_TICK && rvalid_q && age < expiry) begin
				req.we    = 1'b1;
				req.waddr = kept_q[IW-1:0];
				req.wdata = rdata;
			end
			WRITE: req.we = 1'b1;
			default: ;
		endcase
	end

	assign in_ready = (state_q == IDLE) && !out_valid;
	assign count_o = used_q;
	assign out_data = {keep_q, chg_q, 4'(used_q), res_q.seen, res_q.signal, res_q.score,
		res_q.game, res_q.shares, res_q.key, found_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE; used_q <= '0; chg_q <= '0; out_valid <= 1'b0;
			i_q <= '0; j_q <= '0; rvalid_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				IDLE: if (in_valid && in_ready) begin
					kind_q <= kind; item_q <= in_entry; rank_q <= rank;
					found_q <= 1'b0; keep_q <= 1'b0; res_q <= '0; hit_q <= 1'b0;
					i_q <= '0; j_q <= '0; kept_q <= '0; pos_q <= '0; rvalid_q <= 1'b0;
					weak_q <= '0; weak_sig_q <= 8'sd127;
					if (kind == nst_pkg::KIND_CLEAR) begin
						used_q <= '0; chg_q <= chg_q + 32'd1; state_q <= DONE;
					end else if (kind == nst_pkg::KIND_QUERY) state_q <= OUTER;
					else state_q <= SCAN;
				end
				SCAN: begin
					// rdata holds entry i_q-1 when rvalid_q
					if (rvalid_q) begin
						if (kind_q == nst_pkg::KIND_TICK) begin
							if (age < expiry) kept_q <= kept_q + 1'b1;
						end else begin
							if (!hit_q && rdata.key == item_q.key) begin
								hit_q <= 1'b1; slot_q <= IW'(i_q - 1'b1);
							end
							if (rdata.signal < weak_sig_q) begin
								weak_sig_q <= rdata.signal; weak_q <= IW'(i_q - 1'b1);
							end
						end
					end
					// last entry arrives in the cycle after its read; decide after it
					if (i_q < used_q) begin
						i_q <= i_q + 1'b1; rvalid_q <= 1'b1;
					end else if (rvalid_q) rvalid_q <= 1'b0;
					else begin
						if (kind_q == nst_pkg::KIND_TICK) begin
							if (kept_q != used_q) chg_q <= chg_q + 32'd1;
							used_q <= kept_q; state_q <= DONE;
						end else if (hit_q) state_q <= WRITE;
						else if (used_q < Depth) begin
							slot_q <= used_q[IW-1:0]; used_q <= used_q + 1'b1;
							state_q <= WRITE;
						end else if (weak_sig_q < item_q.signal) begin
							slot_q <= weak_q; state_q <= WRITE;
						end else state_q <= DONE;
					end
				end
				WRITE: begin
					keep_q <= 1'b1; chg_q <= chg_q + 32'd1; state_q <= DONE;
				end
				OUTER: begin
					// address i_q issued; next cycle holds candidate
					if (i_q >= used_q) state_q <= DONE;
					else begin
						j_q <= '0; pos_q <= '0; rvalid_q <= 1'b0; state_q <= INNER;
					end
				end
				INNER: begin
					if (!rvalid_q && j_q == '0) cand_q <= rdata;
					if (rvalid_q && ((rdata.signal > cand_q.signal) ||
						(rdata.signal == cand_q.signal && (j_q - 1'b1) < i_q)))
						pos_q <= pos_q + 1'b1;
					if (!rvalid_q && j_q == '0) begin
						rvalid_q <= 1'b1; j_q <= j_q + 1'b1;
					end else if (j_q < used_q) j_q <= j_q + 1'b1;
					else begin
						rvalid_q <= 1'b0;
						if (pos_q + ((rvalid_q && ((rdata.signal > cand_q.signal) ||
							(rdata.signal == cand_q.signal && (j_q - 1'b1) < i_q)))
							? 1'b1 : 1'b0) == CW'(rank_q)) begin
							found_q <= 1'b1; res_q <= cand_q; state_q <= DONE;
						end else begin
							i_q <= i_q + 1'b1; state_q <= OUTER;
						end
					end
				end
				DONE: begin
					out_valid <= 1'b1; state_q <= IDLE; i_q <= '0;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

/* rtl/nearby_sighting_table_unit.sv */
// Top level of the nearby sighting table
//
// channel   | dir | beat
// s_axis    | in  | kind, key, shares, game, score, signal, now, rank
// m_axis    | out | valid, key, shares, game, score, signal, seen, count, changes, kept
// apb       | in  | expiry_ms at address 0
//
// One item at a time: a tick scans all entries through the one memory read
// port; a sighting scans them too and is then dropped or stored; a clear
// skips the scan. A query ranks each candidate against all entries in turn.
// The result waits in the output register; the next beat is taken once it
// leaves. Reset empties the table and sets expiry to 15000; no clearing pass.
`timescale 1ns / 1ps
`include "nearby_sighting_table_unit_macros.svh"
module nearby_sighting_table_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// kind[1:0] key[65:2] shares[66] game[74:67] score[106:75] signal[114:107]
	// now[146:115] rank[149:147]
	input  logic [151:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// valid[0] key[64:1] shares[65] game[73:66] score[105:74] signal[113:106]
	// seen[145:114] count[149:146] changes[181:150] kept[182]
	output logic [183:0] m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	logic [31:0] expiry_q;
	nst_pkg::mem_req_t req;
	nst_pkg::entry_t rdata, in_entry;
	logic [182:0] out_data;
	logic [nst_pkg::CntW-1:0] count;
	logic clear_beat;

	assign pready = 1'b1;
	assign prdata = (paddr == nst_pkg::ADDR_EXPIRY) ? expiry_q : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) expiry_q <= nst_pkg::ResetExpiry;
		else if (psel && penable && pwrite && paddr == nst_pkg::ADDR_EXPIRY) expiry_q <= pwdata;
	end

	// sighting fields, seen time taken from now
	assign in_entry = {s_axis_tdata[65:2], s_axis_tdata[66], s_axis_tdata[74:67],
		s_axis_tdata[106:75], s_axis_tdata[114:107], s_axis_tdata[146:115]};

	nst_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

	nst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.kind(s_axis_tdata[1:0]), .in_entry(in_entry), .rank(s_axis_tdata[149:147]),
		.expiry(expiry_q), .req(req), .rdata(rdata), .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .out_data(out_data), .count_o(count)
	);
	assign m_axis_tdata = {1'b0, out_data};

	assign clear_beat = s_axis_tvalid && s_axis_tready &&
		s_axis_tdata[1:0] == nst_pkg::KIND_CLEAR;

	`NST_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count <= 4'd8, "count over depth")
	`NST_ASSERT_IMP(a_no_accept_busy, clk, arst_n, m_axis_tvalid, !s_axis_tready, "busy accept")
	`NST_ASSERT_NEXT(a_clear_empty, clk, arst_n, clear_beat, count == 4'd0, "clear left entries")
endmodule
